### sv/lik_pkg.sv
// shared types, constants and arithmetic helpers for the leg inverse kinematics block
package lik_pkg;

  // number of cordic rotation cells, at most 32
  localparam int unsigned CORDIC_STAGES = 24;
  // number of square root cells, one result bit each
  localparam int unsigned SQRT_STAGES = 32;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_STROKE = 2'd1,
    STAT_NOSOL  = 2'd2
  } status_e;

  typedef enum logic {
    REG_LINK   = 1'b0,
    REG_STROKE = 1'b1
  } reg_idx_e;

  // one angle under rotation
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_lane_t;

  // data handed between cordic cells
  typedef struct packed {
    cordic_lane_t [2:0] lane;
    logic [2:0][32:0]   pb;
    logic [2:0][31:0]   att;
  } cordic_data_t;

  // data handed between square root cells
  typedef struct packed {
    logic [61:0]        v;
    logic [62:0]        res;
    logic signed [37:0] nz;
    logic               nosol;
  } sqrt_data_t;

  // atan(2^-i) in angle units, 2^31 = pi
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // rounded q30 product: (a*b + 2^29) >> 30, floor shift
  function automatic logic signed [35:0] mq(input logic signed [35:0] a,
                                            input logic signed [35:0] b);
    logic signed [71:0] p;
    logic signed [71:0] r;
    p = 72'(a) * 72'(b);
    r = (p + 72'sd536870912) >>> 30;
    return r[35:0];
  endfunction

  // clamp a cordic output to [-1, 1] in q30
  function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/leg_inverse_kinematics.sv
// top level of the leg inverse kinematics pipeline
//
// channel   direction  transfer when             payload
// command   in         start_i && !busy_o        pos, rot, base, attach
// result    out        done_o                    displacement_o, status_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one leg enters every cycle; busy_o stays low
// pipeline: 24 cordic cells, 7 transform stages, 32 root cells, 1 output
// reset clears the valid chain and both registers; no clearing pass
// results leave as a one-cycle strobe, nothing ever stalls the pipeline
module leg_inverse_kinematics (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic signed [31:0] base_x_i,
  input  logic signed [31:0] base_y_i,
  input  logic signed [31:0] base_z_i,
  input  logic signed [31:0] attach_x_i,
  input  logic signed [31:0] attach_y_i,
  input  logic signed [31:0] attach_z_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [30:0]        cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] displacement_o,
  output logic [1:0]         status_o
);

  logic [30:0] link_q, stroke_q;

  logic                  c_valid [lik_pkg::CORDIC_STAGES+1];
  lik_pkg::cordic_data_t c_data  [lik_pkg::CORDIC_STAGES+1];
  logic                  s_valid [lik_pkg::SQRT_STAGES+1];
  lik_pkg::sqrt_data_t   s_data  [lik_pkg::SQRT_STAGES+1];

  logic               done_q;
  logic signed [31:0] disp_q;
  lik_pkg::status_e   status_q;

  assign busy_o = 1'b0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q   <= '0;
      stroke_q <= '0;
    end else if (cfg_we_i) begin
      case (lik_pkg::reg_idx_e'(cfg_idx_i))
        lik_pkg::REG_LINK:   link_q   <= cfg_wdata_i;
        lik_pkg::REG_STROKE: stroke_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // fold angles into the right half plane and load the first cell
  always_comb begin
    logic [31:0] ang [3];
    logic        fl;
    ang[0] = rot_x_i;
    ang[1] = rot_y_i;
    ang[2] = rot_z_i;
    c_valid[0] = start_i;
    for (int k = 0; k < 3; k++) begin
      fl = ang[k][31] ^ ang[k][30];
      c_data[0].lane[k].x    = 34'sd652032874;
      c_data[0].lane[k].y    = '0;
      c_data[0].lane[k].z    = 34'($signed({ang[k][31] ^ fl, ang[k][30:0]}));
      c_data[0].lane[k].flip = fl;
    end
    c_data[0].pb[0]  = 33'(pos_x_i) - 33'(base_x_i);
    c_data[0].pb[1]  = 33'(pos_y_i) - 33'(base_y_i);
    c_data[0].pb[2]  = 33'(pos_z_i) - 33'(base_z_i);
    c_data[0].att[0] = attach_x_i;
    c_data[0].att[1] = attach_y_i;
    c_data[0].att[2] = attach_z_i;
  end

  // cordic row
  for (genvar i = 0; i < lik_pkg::CORDIC_STAGES; i++) begin : g_cordic
    lik_cordic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (5'(i)),
      .in_valid_i (c_valid[i]),
      .in_i       (c_data[i]),
      .out_valid_o(c_valid[i+1]),
      .out_o      (c_data[i+1])
    );
  end

  lik_xform u_xform (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .link_i     (link_q),
    .in_valid_i (c_valid[lik_pkg::CORDIC_STAGES]),
    .in_i       (c_data[lik_pkg::CORDIC_STAGES]),
    .out_valid_o(s_valid[0]),
    .out_o      (s_data[0])
  );

  // square root row
  for (genvar i = 0; i < lik_pkg::SQRT_STAGES; i++) begin : g_sqrt
    lik_sqrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (5'(i)),
      .in_valid_i (s_valid[i]),
      .in_i       (s_data[i]),
      .out_valid_o(s_valid[i+1]),
      .out_o      (s_data[i+1])
    );
  end

  // displacement, stroke check and saturation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s_valid[lik_pkg::SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [38:0] q;
    logic [38:0]        qa;
    lik_pkg::sqrt_data_t f;
    f  = s_data[lik_pkg::SQRT_STAGES];
    q  = 39'(f.nz) - $signed({8'd0, f.res[30:0]});
    qa = q[38] ? 39'(-q) : 39'(q);
    if (f.nosol) begin
      disp_q   <= '0;
      status_q <= lik_pkg::STAT_NOSOL;
    end else if (q > 39'sd2147483647) begin
      disp_q   <= 32'sh7FFFFFFF;
      status_q <= lik_pkg::STAT_STROKE;
    end else if (q < -39'sd2147483648) begin
      disp_q   <= 32'sh80000000;
      status_q <= lik_pkg::STAT_STROKE;
    end else begin
      disp_q   <= q[31:0];
      status_q <= (qa > 39'(stroke_q)) ? lik_pkg::STAT_STROKE : lik_pkg::STAT_OK;
    end
  end

  assign done_o         = done_q;
  assign displacement_o = disp_q;
  assign status_o       = status_q;

endmodule

### sv/lik_cordic_cell.sv
// one cordic rotation cell, three angles side by side
module lik_cordic_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [4:0]            idx_i,
  input  logic                  in_valid_i,
  input  lik_pkg::cordic_data_t in_i,
  output logic                  out_valid_o,
  output lik_pkg::cordic_data_t out_o
);

  logic                  valid_q;
  lik_pkg::cordic_data_t data_d, data_q;
  logic signed [33:0]    atan_w;

  assign atan_w = {2'b00, lik_pkg::atan_val(idx_i)};

  // micro-rotation toward zero residual angle
  always_comb begin
    logic signed [33:0] x, y, z, dx, dy;
    data_d = in_i;
    for (int k = 0; k < 3; k++) begin
      x  = in_i.lane[k].x;
      y  = in_i.lane[k].y;
      z  = in_i.lane[k].z;
      dx = y >>> idx_i;
      dy = x >>> idx_i;
      if (!z[33]) begin
        data_d.lane[k].x = x - dx;
        data_d.lane[k].y = y + dy;
        data_d.lane[k].z = z - atan_w;
      end else begin
        data_d.lane[k].x = x + dx;
        data_d.lane[k].y = y - dy;
        data_d.lane[k].z = z + atan_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

### sv/lik_xform.sv
// rotation matrix, leg vector and discriminant pipeline
module lik_xform (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [30:0]           link_i,
  input  logic                  in_valid_i,
  input  lik_pkg::cordic_data_t in_i,
  output logic                  out_valid_o,
  output lik_pkg::sqrt_data_t   out_o
);

  logic [6:0] valid_q;

  // stage 0: sin and cos
  logic signed [31:0] sn_d [3], cs_d [3], sn_q [3], cs_q [3];
  logic [2:0][32:0]   pb0_q, pb1_q, pb2_q, pb3_q;
  logic [2:0][31:0]   att0_q, att1_q, att2_q;

  // stage 1: first products
  logic signed [35:0] sxsy_q, cxsy_q, cycz_q, cysz_q, cxsz_q, cxcz_q;
  logic signed [35:0] sxcy_q, sxsz_q, sxcz_q, cxcy_q;
  logic signed [31:0] sy1_q, sz1_q, cz1_q;

  // stage 2: matrix entries
  logic signed [35:0] r_q [3][3];

  // stage 3: matrix times attachment
  logic signed [35:0] t_q [3][3];

  // stage 4: leg vector
  logic signed [37:0] n_q [3];

  // stage 5: squares
  logic [61:0]        ax2_q, ay2_q, l2_q;
  logic               over_q;
  logic signed [37:0] nz5_q;

  // stage 6: discriminant
  lik_pkg::sqrt_data_t out_q;

  // unfold and clamp the cordic results
  always_comb begin
    logic signed [31:0] cx, cy;
    for (int k = 0; k < 3; k++) begin
      cx = lik_pkg::clamp_one(in_i.lane[k].x);
      cy = lik_pkg::clamp_one(in_i.lane[k].y);
      cs_d[k] = in_i.lane[k].flip ? -cx : cx;
      sn_d[k] = in_i.lane[k].flip ? -cy : cy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[5:0], in_valid_i};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    logic [61:0]        s2;
    logic [62:0]        s2w;
    logic signed [37:0] ax, ay;
    logic [37:0]        axm, aym;
    // stage 0
    sn_q   <= sn_d;
    cs_q   <= cs_d;
    pb0_q  <= in_i.pb;
    att0_q <= in_i.att;
    // stage 1
    sxsy_q <= lik_pkg::mq(36'(sn_q[0]), 36'(sn_q[1]));
    cxsy_q <= lik_pkg::mq(36'(cs_q[0]), 36'(sn_q[1]));
    cycz_q <= lik_pkg::mq(36'(cs_q[1]), 36'(cs_q[2]));
    cysz_q <= lik_pkg::mq(36'(cs_q[1]), 36'(sn_q[2]));
    cxsz_q <= lik_pkg::mq(36'(cs_q[0]), 36'(sn_q[2]));
    cxcz_q <= lik_pkg::mq(36'(cs_q[0]), 36'(cs_q[2]));
    sxcy_q <= lik_pkg::mq(36'(sn_q[0]), 36'(cs_q[1]));
    sxsz_q <= lik_pkg::mq(36'(sn_q[0]), 36'(sn_q[2]));
    sxcz_q <= lik_pkg::mq(36'(sn_q[0]), 36'(cs_q[2]));
    cxcy_q <= lik_pkg::mq(36'(cs_q[0]), 36'(cs_q[1]));
    sy1_q  <= sn_q[1];
    sz1_q  <= sn_q[2];
    cz1_q  <= cs_q[2];
    pb1_q  <= pb0_q;
    att1_q <= att0_q;
    // stage 2
    r_q[0][0] <= cycz_q;
    r_q[0][1] <= -cysz_q;
    r_q[0][2] <= 36'(sy1_q);
    r_q[1][0] <= cxsz_q + lik_pkg::mq(sxsy_q, 36'(cz1_q));
    r_q[1][1] <= cxcz_q - lik_pkg::mq(sxsy_q, 36'(sz1_q));
    r_q[1][2] <= -sxcy_q;
    r_q[2][0] <= sxsz_q - lik_pkg::mq(cxsy_q, 36'(cz1_q));
    r_q[2][1] <= sxcz_q + lik_pkg::mq(cxsy_q, 36'(sz1_q));
    r_q[2][2] <= cxcy_q;
    pb2_q  <= pb1_q;
    att2_q <= att1_q;
    // stage 3
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t_q[i][j] <= lik_pkg::mq(r_q[i][j], 36'($signed(att2_q[j])));
      end
    end
    pb3_q <= pb2_q;
    // stage 4
    for (int i = 0; i < 3; i++) begin
      n_q[i] <= 38'($signed(pb3_q[i])) + 38'(t_q[i][0]) + 38'(t_q[i][1])
              + 38'(t_q[i][2]);
    end
    // stage 5
    ax  = n_q[0][37] ? -n_q[0] : n_q[0];
    ay  = n_q[1][37] ? -n_q[1] : n_q[1];
    axm = ax;
    aym = ay;
    ax2_q  <= 62'(axm[30:0]) * 62'(axm[30:0]);
    ay2_q  <= 62'(aym[30:0]) * 62'(aym[30:0]);
    l2_q   <= 62'(link_i) * 62'(link_i);
    over_q <= (axm > 38'(link_i)) || (aym > 38'(link_i));
    nz5_q  <= n_q[2];
    // stage 6
    s2w = 63'(ax2_q) + 63'(ay2_q);
    s2  = s2w[61:0];
    out_q.nosol <= over_q || (s2w > 63'(l2_q));
    out_q.v     <= l2_q - s2;
    out_q.res   <= '0;
    out_q.nz    <= nz5_q;
  end

  assign out_valid_o = valid_q[6];
  assign out_o       = out_q;

endmodule

### sv/lik_sqrt_cell.sv
// one restoring square root cell, one result bit
module lik_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          idx_i,
  input  logic                in_valid_i,
  input  lik_pkg::sqrt_data_t in_i,
  output logic                out_valid_o,
  output lik_pkg::sqrt_data_t out_o
);

  logic                valid_q;
  lik_pkg::sqrt_data_t data_d, data_q;
  logic [63:0]         bit_w, sum_w;

  assign bit_w = 64'd1 << (6'd62 - {idx_i, 1'b0});
  assign sum_w = {1'b0, in_i.res} + bit_w;

  // trial subtract of the next bit pair
  always_comb begin
    data_d = in_i;
    if ({2'b00, in_i.v} >= sum_w) begin
      data_d.v   = in_i.v - sum_w[61:0];
      data_d.res = (in_i.res >> 1) + bit_w[62:0];
    end else begin
      data_d.res = in_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
